// ----- sv/assert_macros.svh -----
// Assertion macros shared by the sampler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert an implication on every clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert a condition that always holds outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("assertion failed");
`endif

// ----- sv/bts_pkg.sv -----
// Shared types and constants of the bilinear texel sampler
package bts_pkg;
  localparam int unsigned MaxWidth   = 128;
  localparam int unsigned MaxHeight  = 128;
  localparam int unsigned PixelDepth = 16384;
  localparam int unsigned AddrW      = $clog2(PixelDepth);
  localparam int unsigned CoordW     = 19;
  localparam int unsigned QDepth     = 2;

  typedef enum logic [1:0] {
    RegWidth   = 2'd0,
    RegHeight  = 2'd1,
    RegChannel = 2'd2
  } reg_idx_e;

  typedef enum logic {
    ActWrite  = 1'b0,
    ActSample = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkRead,
    BkLast,
    BkOut
  } bk_state_e;

  // One decoded command between the front and the back
  typedef struct packed {
    action_e          act;
    logic [AddrW-1:0] waddr;
    logic [31:0]      wdata;
    logic [7:0]       x0;
    logic [7:0]       x1;
    logic [7:0]       y0;
    logic [7:0]       y1;
    logic [7:0]       fx;
    logic [7:0]       fy;
  } cmd_t;
endpackage

// ----- sv/bts_ram.sv -----
// Generic single-port RAM with registered read
module bts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- sv/bts_front.sv -----
// Front end: coordinate scaling, flooring and clamping into commands
module bts_front import bts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              act_i,
  input  logic [AddrW-1:0]  idx_i,
  input  logic [31:0]       word_i,
  input  logic signed [CoordW-1:0] u_i,
  input  logic signed [CoordW-1:0] v_i,
  input  logic [7:0]        w_i,
  input  logic [7:0]        h_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cmd_t              cmd_o
);
  // Stage 1: multiply, stage 2: floor and clamp
  logic         s1_q, s1_d;
  logic         s1_act_q;
  logic [AddrW-1:0] s1_idx_q;
  logic [31:0]  s1_word_q;
  logic signed [28:0] pu_q, pv_q;
  logic [7:0]   w_q, h_q;
  logic         out_q;
  cmd_t         cmd_q;
  logic [7:0]   we, he;

  assign we = (w_i == 8'd0) ? 8'd1 : (w_i > 8'(MaxWidth)) ? 8'(MaxWidth) : w_i;
  assign he = (h_i == 8'd0) ? 8'd1 : (h_i > 8'(MaxHeight)) ? 8'(MaxHeight) : h_i;

  logic adv2, adv1;
  assign adv2 = !out_q || cmd_ready_i;
  assign adv1 = !s1_q || adv2;
  assign in_ready_o = adv1;
  assign s1_d = in_valid_i ? 1'b1 : 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= 1'b0;
      out_q <= 1'b0;
    end else begin
      if (adv1) s1_q <= s1_d;
      if (adv2) out_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      s1_act_q  <= act_i;
      s1_idx_q  <= idx_i;
      s1_word_q <= word_i;
      pu_q <= 29'(u_i * $signed({1'b0, we})) - 29'sh8000;
      pv_q <= 29'(v_i * $signed({1'b0, he})) - 29'sh8000;
      w_q  <= we;
      h_q  <= he;
    end
  end

  function automatic logic [7:0] clampc(input logic signed [12:0] b,
                                        input logic [7:0] sz);
    logic signed [12:0] hi;
    hi = $signed({5'd0, sz}) - 13'sd1;
    if (b < 0) return 8'd0;
    if (b > hi) return hi[7:0];
    return b[7:0];
  endfunction

  logic signed [12:0] bu, bv;
  assign bu = pu_q[28:16];
  assign bv = pv_q[28:16];

  always_ff @(posedge clk_i) begin
    if (adv2 && s1_q) begin
      cmd_q.act   <= action_e'(s1_act_q);
      cmd_q.waddr <= s1_idx_q;
      cmd_q.wdata <= s1_word_q;
      cmd_q.x0    <= clampc(bu, w_q);
      cmd_q.x1    <= clampc(bu + 13'sd1, w_q);
      cmd_q.y0    <= clampc(bv, h_q);
      cmd_q.y1    <= clampc(bv + 13'sd1, h_q);
      cmd_q.fx    <= pu_q[15:8];
      cmd_q.fy    <= pv_q[15:8];
    end
  end

  assign cmd_valid_o = out_q;
  assign cmd_o       = cmd_q;
endmodule

// ----- sv/bts_queue.sv -----
// Short command queue between front and back
module bts_queue import bts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t in_cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t out_cmd_o
);
  localparam int unsigned PtrW = $clog2(QDepth);
  cmd_t ent_q [QDepth];
  logic [PtrW-1:0] rd_q, wr_q;
  logic [PtrW:0]   cnt_q;
  logic push, pop;

  assign in_ready_o  = cnt_q != (PtrW+1)'(QDepth);
  assign out_valid_o = cnt_q != '0;
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  assign out_cmd_o = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
      wr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= in_cmd_i;
  end
endmodule

// ----- sv/bts_back.sv -----
// Back end: image store, four-texel fetch and weighted blend
module bts_back import bts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  input  logic [7:0]  w_i,
  input  logic [2:0]  cnt_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [31:0] res_o
);
  bk_state_e state_q, state_d;
  logic [1:0]  k_q, k_d;
  logic        acc_en_q;
  logic [1:0]  acc_k_q;
  cmd_t        c_q;
  logic [31:0] rdata;
  logic [AddrW-1:0] addr;
  logic        we;
  logic [7:0]  xs, ys;
  logic [14:0] lin;
  logic        out_v_q;
  logic [31:0] out_q;

  assign xs = k_q[0] ? c_q.x1 : c_q.x0;
  assign ys = k_q[1] ? c_q.y1 : c_q.y0;
  assign lin = 15'(ys * w_i) + 15'(xs);
  assign we = (state_q == BkIdle) && cmd_valid_i && (cmd_i.act == ActWrite);
  assign addr = we ? cmd_i.waddr : lin[AddrW-1:0];

  bts_ram #(.Width(32), .Depth(PixelDepth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(cmd_i.wdata), .rdata_o(rdata)
  );

  assign cmd_ready_o = (state_q == BkIdle);

  always_comb begin
    state_d = state_q;
    k_d = k_q;
    case (state_q)
      BkIdle: if (cmd_valid_i && cmd_i.act == ActSample) begin
        state_d = BkRead;
        k_d = 2'd0;
      end
      BkRead: begin
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) state_d = BkLast;
      end
      BkLast: state_d = BkOut;
      BkOut: if (!out_v_q || res_ready_i) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BkIdle;
      k_q      <= '0;
      acc_en_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      acc_en_q <= (state_q == BkRead);
      if (state_q == BkOut && (!out_v_q || res_ready_i)) out_v_q <= 1'b1;
      else if (res_ready_i) out_v_q <= 1'b0;
    end
  end

  logic [8:0]  wx, wy;
  logic [17:0] wt;
  assign wx = acc_k_q[0] ? {1'b0, c_q.fx} : 9'd256 - {1'b0, c_q.fx};
  assign wy = acc_k_q[1] ? {1'b0, c_q.fy} : 9'd256 - {1'b0, c_q.fy};
  assign wt = wx * wy;

  always_ff @(posedge clk_i) begin
    if (state_q == BkIdle && cmd_valid_i) c_q <= cmd_i;
    acc_k_q <= k_q;
  end

  logic [25:0] sum_q [4];
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      if (state_q == BkIdle) sum_q[c] <= 26'd0;
      else if (acc_en_q) sum_q[c] <= sum_q[c] + 26'(rdata[8*c +: 8]) * 26'(wt);
    end
  end

  logic [31:0] res_d;
  logic [25:0] r;
  always_comb begin
    res_d = '0;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      r = sum_q[c] + 26'd32768;
      if (3'(c) < cnt_i) res_d[8*c +: 8] = (r[25:16] > 10'd255) ? 8'd255 : r[23:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BkOut && (!out_v_q || res_ready_i)) out_q <= res_d;
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;
endmodule

// ----- sv/bilinear_texel_sampler_clamped_unit.sv -----
// Top level of the clamped bilinear texel sampler
// Write request: passes the front stages and the queue and is stored when the back end takes it; no result.
// Sample request: the back end handles one sample at a time: a pop, four
// single-port RAM reads, read latency, output.
// Front end accepts one request per cycle, unless stalled by back-pressure, into a two-entry queue.
// Reset clears control state and the configuration registers; image memory is undefined.
`include "assert_macros.svh"
module bilinear_texel_sampler_clamped_unit import bts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // pixel_index, pixel_word, u_coord, v_coord, pad
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // chan0, chan1, chan2, chan3
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  logic [7:0] w_q, h_q;
  logic [2:0] c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= 8'd128;
      h_q <= 8'd128;
      c_q <= 3'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWidth:   w_q <= cfg_data_i;
        RegHeight:  h_q <= cfg_data_i;
        RegChannel: c_q <= cfg_data_i[2:0];
        default:    ;
      endcase
    end
  end

  logic [7:0] w_eff;
  assign w_eff = (w_q == 8'd0) ? 8'd1 : (w_q > 8'(MaxWidth)) ? 8'(MaxWidth) : w_q;

  logic f_v, f_r, b_v, b_r;
  cmd_t f_cmd, b_cmd;

  bts_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .act_i(s_axis_tuser), .idx_i(s_axis_tdata[13:0]), .word_i(s_axis_tdata[45:14]),
    .u_i(s_axis_tdata[64:46]), .v_i(s_axis_tdata[83:65]),
    .w_i(w_q), .h_i(h_q),
    .cmd_valid_o(f_v), .cmd_ready_i(f_r), .cmd_o(f_cmd)
  );

  bts_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_v), .in_ready_o(f_r), .in_cmd_i(f_cmd),
    .out_valid_o(b_v), .out_ready_i(b_r), .out_cmd_o(b_cmd)
  );

  bts_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(b_v), .cmd_ready_o(b_r), .cmd_i(b_cmd),
    .w_i(w_eff), .cnt_i(c_q),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(m_axis_tdata)
  );

  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, ##1 m_axis_tvalid)
  `ASSERT_ALWAYS(a_zero_chan, clk_i, rst_ni, !m_axis_tvalid || c_q > 3'd3 || m_axis_tdata[31:24] == 8'd0)
endmodule

// ----- test/bilinear_texel_sampler_clamped_unit_tb.sv -----
// Testbench of the clamped bilinear texel sampler: a predictor checks every sample result
module bilinear_texel_sampler_clamped_unit_tb;
  import bts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 5000;
  localparam int HoldCycles = 400;
  localparam int PreloadCount = 512;
  localparam int PhaseItems = 170;

  class texel_scoreboard;
    logic [31:0] image_q[PixelDepth];
    int unsigned width_r = 128, height_r = 128, chans_r = 4;
    logic [31:0] pending_q[$];
    int unsigned errors = 0;

    function void set_reg(reg_idx_e idx, logic [7:0] val);
      case (idx)
        RegWidth:   width_r = val;
        RegHeight:  height_r = val;
        RegChannel: chans_r = val[2:0];
        default: ;
      endcase
    endfunction

    function void split(logic signed [CoordW-1:0] c, int unsigned size,
                        output longint base, output int unsigned frac);
      longint p;
      p = longint'(c) * longint'(size) - 64'sh8000;
      base = p >>> 16;
      frac = p[15:8];
    endfunction

    function logic [31:0] texel(longint x, longint y, int unsigned w, int unsigned h);
      longint cx, cy;
      cx = (x < 0) ? 0 : (x > w - 1) ? w - 1 : x;
      cy = (y < 0) ? 0 : (y > h - 1) ? h - 1 : y;
      return image_q[(cx + cy * w) % PixelDepth];
    endfunction

    function void note_request(logic act, logic [87:0] d);
      longint bx, by;
      int unsigned fx, fy, w, h, wt[4];
      logic [31:0] tx[4], res;
      longint acc;
      if (act == ActWrite) begin
        image_q[d[13:0]] = d[45:14];
        return;
      end
      w = (width_r == 0) ? 1 : (width_r > MaxWidth) ? MaxWidth : width_r;
      h = (height_r == 0) ? 1 : (height_r > MaxHeight) ? MaxHeight : height_r;
      split(d[64:46], w, bx, fx);
      split(d[83:65], h, by, fy);
      wt[0] = (256 - fx) * (256 - fy);
      wt[1] = fx * (256 - fy);
      wt[2] = (256 - fx) * fy;
      wt[3] = fx * fy;
      tx[0] = texel(bx, by, w, h);
      tx[1] = texel(bx + 1, by, w, h);
      tx[2] = texel(bx, by + 1, w, h);
      tx[3] = texel(bx + 1, by + 1, w, h);
      for (int ch = 0; ch < 4; ch++) begin
        acc = 0;
        if (ch < chans_r)
          for (int k = 0; k < 4; k++) acc += longint'(tx[k][8*ch +: 8]) * wt[k];
        acc = (acc + 32768) >>> 16;
        res[8*ch +: 8] = (acc > 255) ? 8'd255 : acc[7:0];
      end
      pending_q.push_back(res);
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] exp;
      if (pending_q.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      for (int ch = 0; ch < 4; ch++)
        if (got[8*ch +: 8] !== exp[8*ch +: 8]) begin
          $error("chan%0d expected %0d actual %0d", ch, exp[8*ch +: 8], got[8*ch +: 8]);
          errors++;
        end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_idx_i = '0;
  logic [7:0]  cfg_data_i = '0;

  texel_scoreboard sampler_sb = new();
  int unsigned send_idle = 0, recv_stall = 0, stall_count = 0;
  bit hold_req = 0;

  bilinear_texel_sampler_clamped_unit DUT (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) sampler_sb.note_request(s_axis_tuser, s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready) sampler_sb.check_result(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      stall_count <= 0;
    else if (sampler_sb.pending_q.size() != 0 || s_axis_tvalid) begin
      stall_count <= stall_count + 1;
      if (stall_count >= StallLimit) begin
        $display("bilinear_texel_sampler_clamped_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready = 0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 0;
      end
      m_axis_tready = ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send_request(logic act, logic [13:0] idx, logic [31:0] word,
                              logic [18:0] u, logic [18:0] v);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid = 0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1;
    s_axis_tuser = act;
    s_axis_tdata = {4'd0, v, u, word, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic sample_at(logic [18:0] u, logic [18:0] v);
    send_request(ActSample, 14'($urandom), $urandom, u, v);
  endtask

  task automatic drain();
    s_axis_tvalid = 0;
    while (sampler_sb.pending_q.size() != 0 || hold_req) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [7:0] val);
    cfg_we_i = 1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 0;
    sampler_sb.set_reg(idx, val);
  endtask

  function automatic logic [18:0] rand_coord();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 19'($urandom);
    if (r < 20) return $urandom_range(1, 0) ? 19'h3FFFF : 19'h40000;
    return 19'($urandom_range(32'h12000)) - 19'h1000;
  endfunction

  initial begin
    int unsigned wv[8], hv[8], cv[8];
    wv = '{128, 1, 128, 1, 37, 0, 5, 200};
    hv = '{4, 1, 1, 128, 13, 200, 3, 4};
    cv = '{4, 1, 2, 3, 4, 2, 0, 7};
    repeat (7) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    for (int i = 0; i < PreloadCount; i++)
      send_request(ActWrite, 14'(i), $urandom, 19'($urandom), 19'($urandom));
    send_request(ActWrite, 14'h3FFF, 32'hFFFF_FFFF, '1, '1);
    send_request(ActWrite, 14'h0000, 32'hFFFF_FFFF, '0, '0);
    send_request(ActWrite, 14'h0001, 32'h0000_0000, '0, '0);
    drain();
    write_reg(RegWidth, 8'd128);
    write_reg(RegHeight, 8'd4);
    write_reg(RegChannel, 8'd4);
    sample_at(19'h40000, 19'h40000);
    sample_at(19'h3FFFF, 19'h3FFFF);
    sample_at(19'h00000, 19'h00000);
    sample_at(19'h10000, 19'h10000);
    sample_at(19'h08000, 19'h00100);
    sample_at(19'h40000, 19'h3FFFF);
    sample_at(19'h00080, 19'h0FF80);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(RegWidth, 8'(wv[ph]));
      write_reg(RegHeight, 8'(hv[ph]));
      write_reg(RegChannel, 8'(cv[ph]));
      send_idle  = (ph % 4 == 1) ? 65 : (ph % 4 == 3) ? 8 : 0;
      recv_stall = (ph % 4 == 2) ? 65 : (ph % 4 == 3) ? 8 : 0;
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 0 && n == 40) hold_req = 1;
        if (ph == 5 && n == 120) drain();
        if ($urandom_range(99) < 25)
          send_request(ActWrite, 14'($urandom), $urandom, 19'($urandom), 19'($urandom));
        else
          sample_at(rand_coord(), rand_coord());
      end
      drain();
    end
    repeat (30) @(negedge clk_i);
    if (sampler_sb.errors == 0 && sampler_sb.pending_q.size() == 0)
      $display("bilinear_texel_sampler_clamped_unit: match");
    else
      $display("bilinear_texel_sampler_clamped_unit: mismatch");
    $finish;
  end
endmodule
